>>> rtl/core/gcws_pkg.sv
// ----------------------------------------------------------------------------
// gcws_pkg
// Shared types and constants for the graphic LCD character write sequencer.
// ----------------------------------------------------------------------------
package gcws_pkg;

  localparam int FONT_BYTES_DEF  = 8192;
  localparam int GLYPH_COUNT_DEF = 96;
  localparam int HALF_WIDTH_DEF  = 64;

  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_WIDTH  = 16;
  localparam int MAX_SPAN   = MAX_WIDTH * 3;  // widest glyph times tallest glyph

  localparam logic [7:0] CMD_PAGE  = 8'hB8;
  localparam logic [7:0] CMD_COL   = 8'h40;
  localparam logic [7:0] CODE_BASE = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_WIDTH = 1'b0,
    CFG_FONT_PAGES = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  text_line;
    logic [6:0]  char_column;
    logic [7:0]  char_code;
    logic [12:0] font_addr;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic       right_half;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_PAGE,
    ST_COL,
    ST_DATA
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic write_font;
    logic capture;
    logic setup_a;
    logic setup_b;
    logic emit_page;
    logic emit_col;
    logic emit_data;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ld_ok;
    logic off_screen;
    logic last_page;
    logic last_col;
  } sts_t;

endpackage

>>> rtl/core/glcd_char_write_sequencer.sv
// ----------------------------------------------------------------------------
// glcd_char_write_sequencer
// Text writer for a dual-controller 128x64 graphic LCD with a loadable font.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one transaction per item: draw a glyph,
//   clear a character cell, load one font byte to the font store, or no-op.
//   out_valid/out_stall/out_data carry one LCD bus write per transaction;
//   out_data.last flags the final write of an item.
//   cfg_we/cfg_index/cfg_wdata set font width and font height in pages;
//   write them only while the block is idle.
// Timing:
//   A load is written to the font store as it is accepted. A draw or
//   clear is accepted, then passes setup states SETUP_A (the multiply for
//   x) and SETUP_B (the glyph base address), then makes pages*(width+2)
//   bus writes, one per cycle when the sink does not stall: up to 54 for
//   a 16x3 font. An off-screen cell returns to idle after setup with no
//   writes. The font store is read one byte ahead of the output register,
//   pacing data at one byte per cycle while the sink does not stall.
// Reset: clears the controller and the output valid; width returns to 8,
//   pages to 2. The font store is not cleared and must be loaded first.
// Stall: a stalled output transaction holds; the sequencer waits on it and
//   keeps in_stall high until the item's last write is loaded.
// ----------------------------------------------------------------------------
module glcd_char_write_sequencer #(
  parameter int FONT_BYTES  = gcws_pkg::FONT_BYTES_DEF,
  parameter int GLYPH_COUNT = gcws_pkg::GLYPH_COUNT_DEF,
  parameter int HALF_WIDTH  = gcws_pkg::HALF_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gcws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gcws_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gcws_pkg::out_item_t             out_data
);
  import gcws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // FSM: sequencing only
  gcws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, font store, output register
  gcws_dp #(
    .FONT_BYTES  (FONT_BYTES),
    .GLYPH_COUNT (GLYPH_COUNT),
    .HALF_WIDTH  (HALF_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/core/gcws_ram.sv
// ----------------------------------------------------------------------------
// gcws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/gcws_ctrl.sv
// ----------------------------------------------------------------------------
// gcws_ctrl
// Sequencer FSM: setup, then page command, column command and data bytes
// for each font page.
// ----------------------------------------------------------------------------
module gcws_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  output logic            in_stall,
  input  gcws_pkg::sts_t  sts,
  output gcws_pkg::cmd_t  cmd
);
  import gcws_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_DRAW, KIND_CLEAR: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_SETUP_A;
            end
            KIND_LOAD: cmd.write_font = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SETUP_A: begin
        cmd.setup_a = 1'b1;
        state_nxt   = ST_SETUP_B;
      end
      ST_SETUP_B: begin
        cmd.setup_b = 1'b1;
        state_nxt   = sts.off_screen ? ST_IDLE : ST_PAGE;
      end
      ST_PAGE: begin
        if (sts.ld_ok) begin
          cmd.emit_page = 1'b1;
          state_nxt     = ST_COL;
        end
      end
      ST_COL: begin
        if (sts.ld_ok) begin
          cmd.emit_col = 1'b1;
          state_nxt    = ST_DATA;
        end
      end
      ST_DATA: begin
        if (sts.ld_ok) begin
          cmd.emit_data = 1'b1;
          if (sts.last_col) begin
            state_nxt = sts.last_page ? ST_IDLE : ST_PAGE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.write_font, cmd.capture, cmd.setup_a, cmd.setup_b,
              cmd.emit_page, cmd.emit_col, cmd.emit_data}))
    else $error("more than one datapath command at once");
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_page || cmd.emit_col || cmd.emit_data) |-> sts.ld_ok)
    else $error("output register overwritten while stalled");
  a_col_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_col |=> (state_r == ST_DATA))
    else $error("column command not followed by data");
  a_capture_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_SETUP_A))
    else $error("draw transaction did not start setup");
`endif

endmodule

>>> rtl/core/gcws_dp.sv
// ----------------------------------------------------------------------------
// gcws_dp
// Datapath: config registers, geometry setup, font store, counters and the
// output register.
// ----------------------------------------------------------------------------
module gcws_dp #(
  parameter int FONT_BYTES  = gcws_pkg::FONT_BYTES_DEF,
  parameter int GLYPH_COUNT = gcws_pkg::GLYPH_COUNT_DEF,
  parameter int HALF_WIDTH  = gcws_pkg::HALF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  gcws_pkg::in_item_t            in_data,
  output gcws_pkg::out_item_t           out_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  gcws_pkg::cmd_t                cmd,
  output gcws_pkg::sts_t                sts
);
  import gcws_pkg::*;

  localparam int AW    = $clog2(FONT_BYTES);
  localparam int SPAN_W = $clog2(GLYPH_COUNT * MAX_SPAN);
  localparam int CW    = (SPAN_W > AW) ? SPAN_W : AW;

  // config
  logic [4:0] font_width_r;
  logic [1:0] font_pages_r;
  logic [4:0] w_eff;
  logic [1:0] p_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_width_r <= 5'd8;
      font_pages_r <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FONT_WIDTH: font_width_r <= cfg_wdata;
        CFG_FONT_PAGES: font_pages_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = font_width_r;
    if (font_width_r == 5'd0) begin
      w_eff = 5'd1;
    end else if (font_width_r > 5'(MAX_WIDTH)) begin
      w_eff = 5'(MAX_WIDTH);
    end
    p_eff = (font_pages_r == 2'd0) ? 2'd1 : font_pages_r;
  end

  // item and geometry
  logic [4:0]    w_r;
  logic [1:0]    p_r;
  logic [2:0]    line_r;
  logic [6:0]    col_r;
  logic [7:0]    code_r;
  logic          blank_r;
  logic [11:0]   x_r;
  logic [5:0]    wp_r;
  logic [7:0]    glyph_r;
  logic          right_r;
  logic [5:0]    xc_r;
  logic [2:0]    page_r;
  logic [1:0]    pidx_r;
  logic [3:0]    cidx_r;
  logic [CW-1:0] addr_r;
  logic          byte_ok_r;
  logic          code_bad;
  logic [11:0]   xc_full;

  assign code_bad = (code_r < CODE_BASE) ||
                    (32'(code_r - CODE_BASE) >= GLYPH_COUNT);
  assign xc_full  = (32'(x_r) < HALF_WIDTH) ? x_r : 12'(32'(x_r) - HALF_WIDTH);

  // font store
  logic          rd_en;
  logic [7:0]    rd_data;
  logic          wr_en;

  assign rd_en = cmd.emit_col || (cmd.emit_data && !sts.last_col);
  assign wr_en = cmd.write_font && (32'(in_data.font_addr) < FONT_BYTES);

  gcws_ram #(
    .WIDTH(8),
    .DEPTH(FONT_BYTES)
  ) u_font (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.font_addr)),
    .wr_data (in_data.font_byte),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_r     <= w_eff;
      p_r     <= p_eff;
      line_r  <= in_data.text_line;
      col_r   <= in_data.char_column;
      code_r  <= in_data.char_code;
      blank_r <= (kind_t'(in_data.kind) == KIND_CLEAR);
    end
    if (cmd.setup_a) begin
      x_r     <= 12'(col_r) * 12'(w_r);
      wp_r    <= 6'(w_r) * 6'(p_r);
      page_r  <= 3'(line_r * p_r);
      glyph_r <= code_r - CODE_BASE;
      blank_r <= blank_r || code_bad;
    end
    if (cmd.setup_b) begin
      addr_r  <= CW'(glyph_r) * CW'(wp_r);
      right_r <= (32'(x_r) >= HALF_WIDTH);
      xc_r    <= xc_full[5:0];
      pidx_r  <= 2'd0;
    end
    if (cmd.emit_page) begin
      cidx_r <= 4'd0;
    end
    if (rd_en) begin
      byte_ok_r <= !blank_r && (32'(addr_r) < FONT_BYTES);
      addr_r    <= addr_r + 1'b1;
    end
    if (cmd.emit_data) begin
      if (sts.last_col) begin
        page_r <= page_r + 1'b1;
        pidx_r <= pidx_r + 1'b1;
      end else begin
        cidx_r <= cidx_r + 1'b1;
      end
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      emit;

  assign emit = cmd.emit_page || cmd.emit_col || cmd.emit_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_page) begin
      out_data_r <= '{right_half: right_r, is_data: 1'b0,
                      bus_byte: CMD_PAGE + {5'd0, page_r}, last: 1'b0};
    end else if (cmd.emit_col) begin
      out_data_r <= '{right_half: right_r, is_data: 1'b0,
                      bus_byte: CMD_COL + {2'd0, xc_r}, last: 1'b0};
    end else if (cmd.emit_data) begin
      out_data_r <= '{right_half: right_r, is_data: 1'b1,
                      bus_byte: byte_ok_r ? rd_data : 8'd0,
                      last: sts.last_col && sts.last_page};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.ld_ok      = !out_valid_r || !out_stall;
  assign sts.off_screen = (32'(x_r) >= 2 * HALF_WIDTH);
  assign sts.last_page  = (pidx_r == p_r - 2'd1);
  assign sts.last_col   = ({1'b0, cidx_r} == w_r - 5'd1);

endmodule

>>> tb/tb_glcd_char_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glcd_char_write_sequencer
// Self-checking bench for the graphic LCD character write sequencer.
// A queue-fed driver sends font loads, draws, clears and no-ops with random
// gaps while the sink stalls at random. Every accepted transaction is run
// through a local model of the font store and the write sequence, and each
// LCD bus write is compared with the oldest predicted one. The font size is
// changed between phases, only with the block drained.
// ----------------------------------------------------------------------------
module tb_glcd_char_write_sequencer;
  import gcws_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 16;       // covers setup of an off-screen item
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 350;      // transaction budget, loads included
  localparam int NUM_PHASES    = 10;
  localparam int MAX_REPORTS   = 10;
  localparam int SCREEN_W      = 2 * HALF_WIDTH_DEF;
  localparam int POOL_GLYPHS   = 4;        // small glyph pool keeps loads down

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  glcd_char_write_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bookkeeping shared by stimulus, driver and monitor
  // --------------------------------------------------------------------------
  in_item_t  pending_items[$];     // transactions waiting for the driver
  out_item_t bus_writes_due[$];    // predicted LCD bus writes, oldest first
  int        items_queued  = 0;
  int        items_taken   = 0;
  int        writes_seen   = 0;
  int        mismatch_count = 0;
  int        settings_run  = 0;
  int        cycle_count   = 0;

  // predictor state: its own copy of the font store and font size registers
  logic [7:0]  glyph_rom[0:FONT_BYTES_DEF-1];
  logic [4:0]  cfg_width_q;
  logic [1:0]  cfg_pages_q;

  // stimulus side: which store bytes have been loaded, and the font size in use
  bit          font_loaded[0:FONT_BYTES_DEF-1];
  int          gen_w = 8;
  int          gen_p = 2;

  // font size phases, raw register values; out-of-range ones included
  int phase_w[NUM_PHASES] = '{1, 16, 0, 31, 5, 17, 12, 3, 0, 8};
  int phase_p[NUM_PHASES] = '{1, 3, 0, 3, 2, 1, 3, 2, 0, 2};

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one transaction at a time from pending_items, random gaps between
  // them, and occasional quiet stretches with no gaps at all.
  // --------------------------------------------------------------------------
  int src_gap   = 0;
  int src_quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      src_gap   <= 0;
      src_quiet <= 0;
    end else if (!in_valid || !in_stall) begin
      if (src_quiet > 0) src_quiet <= src_quiet - 1;
      else if ($urandom_range(0, 49) == 0) src_quiet <= $urandom_range(30, 120);
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        src_gap  <= (src_quiet != 0) ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink stall pattern, same shape as the source gaps.
  int sink_left  = 0;
  int sink_quiet = 0;

  always @(posedge clk) begin
    int len;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      sink_left  <= 0;
      sink_quiet <= 0;
    end else if (sink_left > 0) begin
      out_stall <= 1'b1;
      sink_left <= sink_left - 1;
    end else if (sink_quiet > 0) begin
      out_stall  <= 1'b0;
      sink_quiet <= sink_quiet - 1;
    end else if ($urandom_range(0, 59) == 0) begin
      out_stall  <= 1'b0;
      sink_quiet <= $urandom_range(30, 150);
    end else begin
      len = gap_len();
      out_stall <= (len != 0);
      sink_left <= (len != 0) ? len - 1 : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: expands one accepted transaction into its bus writes.
  // Per page: page command, column command, then width data bytes.
  // --------------------------------------------------------------------------
  task automatic predict_writes(input in_item_t t);
    int        w, p, x, xc, g, total, k, addr, i, c;
    logic      rh, blank;
    out_item_t wr;
    if (t.kind == KIND_LOAD) begin
      if (t.font_addr < FONT_BYTES_DEF) glyph_rom[t.font_addr] = t.font_byte;
    end else if (t.kind != KIND_NOP) begin
      // width 0 acts as 1, anything above 16 as 16; zero pages act as one
      w = (cfg_width_q == 0) ? 1 : (cfg_width_q > MAX_WIDTH) ? MAX_WIDTH : cfg_width_q;
      p = (cfg_pages_q == 0) ? 1 : cfg_pages_q;
      x = t.char_column * w;
      if (x < SCREEN_W) begin              // off-screen cells emit nothing
        rh = (x >= HALF_WIDTH_DEF);
        xc = rh ? x - HALF_WIDTH_DEF : x;
        g  = int'(t.char_code) - int'(CODE_BASE);
        // codes outside the font render as a blank cell
        blank = (t.kind == KIND_CLEAR) || (g < 0) || (g >= GLYPH_COUNT_DEF);
        total = p * (w + 2);
        k = 0;
        for (i = 0; i < p; i++) begin
          for (c = -2; c < w; c++) begin
            wr.right_half = rh;
            wr.is_data    = (c >= 0);
            if (c == -2) begin
              wr.bus_byte = 8'(CMD_PAGE + ((t.text_line * p + i) & 7));
            end else if (c == -1) begin
              wr.bus_byte = 8'(CMD_COL + (xc & 63));
            end else if (blank) begin
              wr.bus_byte = 8'h00;
            end else begin
              addr = g * w * p + w * i + c;
              wr.bus_byte = (addr < FONT_BYTES_DEF) ? glyph_rom[addr] : 8'h00;
            end
            wr.last = (k == total - 1);
            k++;
            bus_writes_due.push_back(wr);
          end
        end
      end
    end
  endtask

  task automatic check_write(input out_item_t got);
    out_item_t want;
    writes_seen++;
    if (bus_writes_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: unexpected bus write rh=%0d dat=%0d byte=%02h last=%0d",
                 $realtime, got.right_half, got.is_data, got.bus_byte, got.last);
    end else begin
      want = bus_writes_due.pop_front();
      if (got.right_half !== want.right_half || got.is_data !== want.is_data ||
          got.bus_byte !== want.bus_byte || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: bus write %0d mismatch:", $realtime, writes_seen);
          $display("  expected rh=%0d dat=%0d byte=%02h last=%0d",
                   want.right_half, want.is_data, want.bus_byte, want.last);
          $display("  got      rh=%0d dat=%0d byte=%02h last=%0d",
                   got.right_half, got.is_data, got.bus_byte, got.last);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: register writes, accepted inputs and accepted bus writes, all
  // sampled at the clock edge before any of this step's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_q = 5'd8;
      cfg_pages_q = 2'd2;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FONT_WIDTH: cfg_width_q = cfg_wdata;
          CFG_FONT_PAGES: cfg_pages_q = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_writes(in_data);
        items_taken++;                     // after the push, see wait_drained
      end
      if (out_valid && !out_stall) check_write(out_data);
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bus writes still due",
               cycle_count, bus_writes_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  task automatic queue_item(input in_item_t t);
    pending_items.push_back(t);
    items_queued++;
    if (t.kind == KIND_LOAD) font_loaded[t.font_addr] = 1'b1;
  endtask

  task automatic queue_load(input int addr, input int value);
    in_item_t t;
    t = random_item();
    t.kind      = KIND_LOAD;
    t.font_addr = 13'(addr);
    t.font_byte = 8'(value);
    queue_item(t);
  endtask

  // Loads whatever bytes of glyph g are still missing at the current font size,
  // so no draw ever reads a store byte that was never written.
  task automatic load_glyph(input int g);
    int a;
    for (a = g * gen_w * gen_p; a < (g + 1) * gen_w * gen_p; a++)
      if (!font_loaded[a]) queue_load(a, $urandom_range(0, 255));
  endtask

  task automatic queue_cell(input kind_t kind, input int line, input int col,
                            input int code);
    in_item_t t;
    t = random_item();
    t.kind        = kind;
    t.text_line   = 3'(line);
    t.char_column = 7'(col);
    t.char_code   = 8'(code);
    queue_item(t);
  endtask

  // Sender holds until every queued transaction is taken and every predicted
  // write has come back, then lets the block finish any silent setup.
  task automatic wait_drained();
    do @(posedge clk);
    while (items_taken != items_queued || bus_writes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_font(input int w_raw, input int p_raw);
    logic [CFG_DATA_W-1:0] pages_word;
    wait_drained();
    pages_word = CFG_DATA_W'($urandom);    // upper bits are don't-care
    pages_word[1:0] = 2'(p_raw);
    cfg_write(CFG_FONT_WIDTH, CFG_DATA_W'(w_raw));
    cfg_write(CFG_FONT_PAGES, pages_word);
    gen_w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
    gen_p = (p_raw == 0) ? 1 : p_raw;
    settings_run++;
  endtask

  // Random mix: mostly draws of loaded glyphs on screen, plus blank codes,
  // clears, no-ops, stray loads and off-screen cells. count covers every
  // queued transaction, the glyph loads included.
  task automatic run_random(input int count);
    int start, r, g, col;
    bit drained;
    in_item_t t;
    start   = items_queued;
    drained = 1'b0;
    while (items_queued - start < count) begin
      if (!drained && items_queued - start >= count / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      r   = $urandom_range(0, 99);
      col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (SCREEN_W - 1) / gen_w)
                                         : $urandom_range(0, 127);
      if (r < 70) begin
        if ($urandom_range(0, 9) < 8) begin
          // any glyph of the font only while glyphs are cheap to load
          if ($urandom_range(0, 9) < 7 || gen_w * gen_p > 8)
            g = $urandom_range(0, POOL_GLYPHS - 1);
          else
            g = $urandom_range(0, GLYPH_COUNT_DEF - 1);
          load_glyph(g);
          queue_cell(KIND_DRAW, $urandom_range(0, 7), col, g + CODE_BASE);
        end else begin
          queue_cell(KIND_DRAW, $urandom_range(0, 7), col,
                     $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(128, 255));
        end
      end else if (r < 85) begin
        queue_cell(KIND_CLEAR, $urandom_range(0, 7), col, $urandom_range(0, 255));
      end else if (r < 90) begin
        t = random_item();
        t.kind = KIND_NOP;
        queue_item(t);
      end else begin
        queue_load($urandom_range(0, FONT_BYTES_DEF - 1), $urandom_range(0, 255));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int i, per_phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    settings_run = 1;                      // reset font size: 8 wide, 2 pages

    // Directed, at the reset font size: last glyph of the font with all-ones
    // and all-zeros columns, both controllers, page wrap, off-screen cells,
    // blank codes, clear, no-op and a load to the top store address.
    for (i = 0; i < 16; i++)
      queue_load((GLYPH_COUNT_DEF - 1) * 16 + i,
                 (i == 0) ? 255 : (i == 1) ? 0 : $urandom_range(0, 255));
    queue_cell(KIND_DRAW, 0, 0, 127);
    queue_cell(KIND_DRAW, 7, 7, 127);      // x 56, pages wrap past 7
    queue_cell(KIND_DRAW, 3, 8, 127);      // first column of right controller
    queue_cell(KIND_DRAW, 5, 15, 127);     // rightmost full cell
    queue_cell(KIND_DRAW, 1, 16, 127);     // x 128: off screen
    queue_cell(KIND_DRAW, 7, 127, 127);
    queue_cell(KIND_CLEAR, 2, 4, 127);
    queue_cell(KIND_CLEAR, 6, 127, 255);
    queue_cell(KIND_DRAW, 4, 3, 0);        // codes outside the font
    queue_cell(KIND_DRAW, 4, 9, 31);
    queue_cell(KIND_DRAW, 4, 10, 128);
    queue_cell(KIND_DRAW, 4, 11, 255);
    queue_cell(KIND_NOP, 7, 127, 255);
    queue_load(FONT_BYTES_DEF - 1, 255);

    per_phase = (RANDOM_ITEMS - items_queued) / (NUM_PHASES + 1);
    run_random(per_phase);
    for (i = 0; i < NUM_PHASES; i++) begin
      set_font(phase_w[i], phase_p[i]);
      run_random(per_phase);
    end

    wait_drained();
    if (bus_writes_due.size() != 0) begin
      mismatch_count += bus_writes_due.size();
      $display("%0d predicted bus writes never arrived", bus_writes_due.size());
    end

    $display("Ran %0d transactions under %0d font sizes; %0d LCD bus writes checked.",
             items_taken, settings_run, writes_seen);
    $display("Draws, clears, blank codes, off-screen cells and no-ops; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
